/* hdl/rmq_pkg.sv */
package rmq_pkg;

  localparam int FIELD_W     = 9;
  localparam int COUNT_W     = 10;
  localparam int MODE_VAL_W  = 9;
  localparam int RECIP_SH    = 20;
  localparam int MOD_W       = 14;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic                  empty;
    logic [MODE_VAL_W-1:0] value;
    logic [COUNT_W-1:0]    count;
  } res_t;

endpackage

/* hdl/range_mode_query.sv */
// Range mode query engine. Write items store one value into the element
// memory. A query walks its range with the element memory's single read
// port, once to build a histogram in the count memory (one position per
// cycle, with a bypass for back-to-back hits on the same value) and once
// more to zero the counts it touched. An empty range skips both walks and
// goes straight to its result. After reset the count memory is cleared one
// entry per cycle, and no item is taken until the clear is done. Results
// sit in an output register, so a new item can be accepted while one waits.
module range_mode_query #(
  parameter int ARRAY_SIZE  = 512,
  parameter int VALUE_RANGE = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // position, element_value, range_start, range_end
  input  logic [rmq_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [0:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // mode_value, mode_count
  output logic [rmq_pkg::OUT_DATA_W-1:0] out_tdata,
  // empty_range
  output logic [0:0]                     out_tuser
);

  localparam int FW = rmq_pkg::FIELD_W;
  localparam int CW = rmq_pkg::COUNT_W;
  localparam int MW = rmq_pkg::MODE_VAL_W;

  logic          res_valid;
  logic          res_ready;
  rmq_pkg::res_t res;
  logic          out_vld_r;
  rmq_pkg::res_t out_r;

  rmq_core #(
    .ARRAY_SIZE (ARRAY_SIZE),
    .VALUE_RANGE(VALUE_RANGE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (rmq_pkg::op_t'(in_tuser[0])),
    .in_pos   (in_tdata[FW-1:0]),
    .in_val   (in_tdata[2*FW-1:FW]),
    .in_lo    (in_tdata[3*FW-1:2*FW]),
    .in_hi    (in_tdata[4*FW-1:3*FW]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(rmq_pkg::OUT_DATA_W - MW - CW){1'b0}}, out_r.count, out_r.value};
  assign out_tuser  = out_r.empty;

endmodule

/* hdl/rmq_wrap.sv */
module rmq_wrap #(
  parameter int MODULUS = 512,
  parameter int OUT_W   = 9
) (
  input  logic                        clk,
  input  logic [rmq_pkg::FIELD_W-1:0] din,
  output logic [OUT_W-1:0]            dout
);

  localparam int FW     = rmq_pkg::FIELD_W;
  localparam int SH     = rmq_pkg::RECIP_SH;
  localparam int MW     = rmq_pkg::MOD_W;
  localparam int PROD_W = FW + SH;
  localparam int P2_W   = FW + MW;
  localparam int RECIP  = (1 << SH) / MODULUS;

  localparam logic [SH-1:0] RECIP_V = SH'(RECIP);
  localparam logic [MW-1:0] MOD_V   = MW'(MODULUS);

  logic [FW-1:0]     x_r;
  logic [FW-1:0]     q_r;
  logic [OUT_W-1:0]  dout_r;
  logic [PROD_W-1:0] prod;
  logic [P2_W-1:0]   prod2;
  logic [FW:0]       r_raw;
  logic [MW-1:0]     r_ext;
  logic [MW-1:0]     r_fin;

  // quotient estimate, at most one low
  assign prod  = PROD_W'(din) * PROD_W'(RECIP_V);
  assign prod2 = P2_W'(q_r) * P2_W'(MOD_V);
  assign r_raw = {1'b0, x_r} - prod2[FW:0];
  assign r_ext = MW'(r_raw);
  assign r_fin = (r_ext >= MOD_V) ? (r_ext - MOD_V) : r_ext;

  always_ff @(posedge clk) begin
    x_r    <= din;
    q_r    <= prod[PROD_W-1 -: FW];
    dout_r <= OUT_W'(r_fin);
  end

  assign dout = dout_r;

endmodule

/* hdl/rmq_core.sv */
module rmq_core #(
  parameter int ARRAY_SIZE  = 512,
  parameter int VALUE_RANGE = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rmq_pkg::op_t                in_op,
  input  logic [rmq_pkg::FIELD_W-1:0] in_pos,
  input  logic [rmq_pkg::FIELD_W-1:0] in_val,
  input  logic [rmq_pkg::FIELD_W-1:0] in_lo,
  input  logic [rmq_pkg::FIELD_W-1:0] in_hi,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rmq_pkg::res_t               res
);

  localparam int IDX_W = $clog2(ARRAY_SIZE);
  localparam int VAL_W = $clog2(VALUE_RANGE);
  localparam int FW    = rmq_pkg::FIELD_W;
  localparam int CW    = rmq_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WRAP0,
    ST_WRAP1,
    ST_DECODE,
    ST_COUNT,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  state_t           state_r, state_nxt;
  rmq_pkg::op_t     op_r, op_nxt;
  logic [FW-1:0]    pos_r, pos_nxt;
  logic [FW-1:0]    val_r, val_nxt;
  logic [FW-1:0]    lo_r, lo_nxt;
  logic [FW-1:0]    hi_r, hi_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             issue_r, issue_nxt;
  logic             s1_vld_r, s1_vld_nxt;
  logic             s2_vld_r, s2_vld_nxt;
  logic [VAL_W-1:0] s2_v_r, s2_v_nxt;
  logic             fwd_r, fwd_nxt;
  logic [CW-1:0]    last_c_r, last_c_nxt;
  logic [CW-1:0]    best_c_r, best_c_nxt;
  logic [VAL_W-1:0] best_v_r, best_v_nxt;
  logic             empty_r, empty_nxt;
  logic [VAL_W-1:0] init_r, init_nxt;

  logic [FW-1:0]    a_raw;
  logic [IDX_W-1:0] a_w;
  logic [IDX_W-1:0] b_w;
  logic [VAL_W-1:0] v_w;

  logic [VAL_W-1:0] elem_mem [ARRAY_SIZE];
  logic [VAL_W-1:0] elem_q_r;
  logic             elem_we;
  logic             elem_re;
  logic [CW-1:0]    cnt_mem [VALUE_RANGE];
  logic [CW-1:0]    cnt_q_r;
  logic             cnt_re;
  logic             cnt_we;
  logic [VAL_W-1:0] cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic [CW-1:0]    cnt_base;
  logic [CW-1:0]    cnt_inc;

  assign a_raw = (op_r == rmq_pkg::OP_WRITE) ? pos_r : lo_r;

  rmq_wrap #(.MODULUS(ARRAY_SIZE), .OUT_W(IDX_W)) u_wrap_a (
    .clk (clk),
    .din (a_raw),
    .dout(a_w)
  );

  rmq_wrap #(.MODULUS(ARRAY_SIZE), .OUT_W(IDX_W)) u_wrap_b (
    .clk (clk),
    .din (hi_r),
    .dout(b_w)
  );

  rmq_wrap #(.MODULUS(VALUE_RANGE), .OUT_W(VAL_W)) u_wrap_v (
    .clk (clk),
    .din (val_r),
    .dout(v_w)
  );

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[a_w] <= v_w;
    end
    if (elem_re) begin
      elem_q_r <= elem_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q_r <= cnt_mem[elem_q_r];
    end
  end

  // bypass the count written in the same cycle as the read
  assign cnt_base = fwd_r ? last_c_r : cnt_q_r;
  assign cnt_inc  = (cnt_base == rmq_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    issue_nxt  = issue_r;
    s1_vld_nxt = s1_vld_r;
    s2_vld_nxt = s2_vld_r;
    s2_v_nxt   = s2_v_r;
    fwd_nxt    = fwd_r;
    last_c_nxt = last_c_r;
    best_c_nxt = best_c_r;
    best_v_nxt = best_v_r;
    empty_nxt  = empty_r;
    init_nxt   = init_r;
    elem_we    = 1'b0;
    elem_re    = 1'b0;
    cnt_re     = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = s2_v_r;
    cnt_wdata  = '0;
    unique case (state_r)
      ST_INIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = init_r;
        if (init_r == VAL_W'(VALUE_RANGE - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          init_nxt = init_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          pos_nxt   = in_pos;
          val_nxt   = in_val;
          lo_nxt    = in_lo;
          hi_nxt    = in_hi;
          state_nxt = ST_WRAP0;
        end
      end
      ST_WRAP0: begin
        state_nxt = ST_WRAP1;
      end
      ST_WRAP1: begin
        state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (op_r == rmq_pkg::OP_WRITE) begin
          elem_we   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          best_c_nxt = '0;
          best_v_nxt = '0;
          empty_nxt  = (a_w > b_w);
          if (a_w > b_w) begin
            state_nxt = ST_RESULT;
          end else begin
            idx_nxt   = a_w;
            issue_nxt = 1'b1;
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        // element read
        if (issue_r) begin
          elem_re    = 1'b1;
          s1_vld_nxt = 1'b1;
          if (idx_r == b_w) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          s1_vld_nxt = 1'b0;
        end
        // count read
        if (s1_vld_r) begin
          cnt_re     = 1'b1;
          s2_vld_nxt = 1'b1;
          s2_v_nxt   = elem_q_r;
          fwd_nxt    = s2_vld_r && (s2_v_r == elem_q_r);
        end else begin
          s2_vld_nxt = 1'b0;
        end
        // count write and mode update
        if (s2_vld_r) begin
          cnt_we     = 1'b1;
          cnt_waddr  = s2_v_r;
          cnt_wdata  = cnt_inc;
          last_c_nxt = cnt_inc;
          if ((cnt_inc > best_c_r) || ((cnt_inc == best_c_r) && (s2_v_r < best_v_r))) begin
            best_c_nxt = cnt_inc;
            best_v_nxt = s2_v_r;
          end
        end
        if (!issue_r && !s1_vld_r && !s2_vld_r) begin
          idx_nxt   = a_w;
          issue_nxt = 1'b1;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (issue_r) begin
          elem_re    = 1'b1;
          s1_vld_nxt = 1'b1;
          if (idx_r == b_w) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          s1_vld_nxt = 1'b0;
        end
        if (s1_vld_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = elem_q_r;
          cnt_wdata = '0;
        end
        if (!issue_r && !s1_vld_r) begin
          idx_nxt   = '0;
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      idx_r    <= '0;
      issue_r  <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
      best_c_r <= '0;
      best_v_r <= '0;
      empty_r  <= 1'b0;
      init_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      issue_r  <= issue_nxt;
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      fwd_r    <= fwd_nxt;
      best_c_r <= best_c_nxt;
      best_v_r <= best_v_nxt;
      empty_r  <= empty_nxt;
      init_r   <= init_nxt;
    end
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    s2_v_r   <= s2_v_nxt;
    last_c_r <= last_c_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESULT);
  assign res.empty = empty_r;
  assign res.value = rmq_pkg::MODE_VAL_W'(best_v_r);
  assign res.count = best_c_r;

`ifndef SYNTHESIS
  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT && s2_vld_r) |-> (cnt_wdata != '0))
    else $error("counting walk wrote a zero count");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT && $past(state_r == ST_COUNT)) |-> (best_c_r >= $past(best_c_r)))
    else $error("best count dropped during counting walk");

  a_walk_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_r || s1_vld_r || s2_vld_r) |-> (state_r == ST_COUNT || state_r == ST_CLEAR))
    else $error("walk pipeline active outside a walk");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.empty) |-> (res.count == '0 && res.value == '0))
    else $error("empty range result carries data");
`endif

endmodule

/* tb/rmq_checker.sv */
`timescale 1ns / 1ps

module rmq_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // position, element_value, range_start, range_end
  input  logic [rmq_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [0:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // mode_value, mode_count
  input  logic [rmq_pkg::OUT_DATA_W-1:0] out_tdata,
  // empty_range
  input  logic [0:0]                     out_tuser,
  output int                             mismatch_cnt,
  output int                             outstanding,
  output int                             checked_cnt
);

  localparam int DEPTH = 512;
  localparam int FW    = rmq_pkg::FIELD_W;

  logic [FW-1:0]  elem_mem [DEPTH];
  rmq_pkg::res_t  mode_q [$];
  int             err_cnt;
  int             res_cnt;

  function automatic rmq_pkg::res_t predict_mode(logic [FW-1:0] lo, logic [FW-1:0] hi);
    int            hist [DEPTH];
    int            best_cnt;
    int            best_val;
    int            v;
    rmq_pkg::res_t r;
    r = '0;
    if (lo > hi) begin
      r.empty = 1'b1;
      return r;
    end
    foreach (hist[k]) hist[k] = 0;
    best_cnt = 0;
    best_val = 0;
    for (int i = int'(lo); i <= int'(hi); i++) begin
      v = int'(elem_mem[i]);
      if (hist[v] < int'(rmq_pkg::COUNT_MAX)) hist[v]++;
      if (hist[v] > best_cnt || (hist[v] == best_cnt && v < best_val)) begin
        best_cnt = hist[v];
        best_val = v;
      end
    end
    r.value = best_val[rmq_pkg::MODE_VAL_W-1:0];
    r.count = best_cnt[rmq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    rmq_pkg::res_t got;
    rmq_pkg::res_t want;
    if (!rst_n) begin
      mode_q.delete();
      foreach (elem_mem[k]) elem_mem[k] = '0;
      err_cnt = 0;
      res_cnt = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (rmq_pkg::op_t'(in_tuser[0]) == rmq_pkg::OP_WRITE) begin
          elem_mem[in_tdata[8:0]] = in_tdata[17:9];
        end else begin
          mode_q.insert(mode_q.size(), predict_mode(in_tdata[26:18], in_tdata[35:27]));
        end
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[8:0];
        got.count = out_tdata[18:9];
        got.empty = out_tuser[0];
        res_cnt++;
        if (mode_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%t: result with no query outstanding: value=%0d count=%0d empty=%0d",
                     $realtime, got.value, got.count, got.empty);
        end else begin
          want = mode_q.pop_front();
          if (got.value !== want.value || got.count !== want.count ||
              got.empty !== want.empty) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $write("%t: mode mismatch: expected value=%0d count=%0d empty=%0d,",
                     $realtime, want.value, want.count, want.empty);
              $display(" got value=%0d count=%0d empty=%0d",
                       got.value, got.count, got.empty);
            end
          end
        end
      end
    end
    mismatch_cnt <= err_cnt;
    checked_cnt  <= res_cnt;
    outstanding  <= mode_q.size();
  end

endmodule

/* tb/tb_range_mode_query.sv */
`timescale 1ns / 1ps

module tb_range_mode_query;

  localparam int DEPTH          = 512;
  localparam int FW             = rmq_pkg::FIELD_W;
  localparam int RANDOM_ITEMS   = 425;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 40;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [rmq_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]                     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [rmq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                     out_tuser;

  int mismatch_cnt;
  int outstanding;
  int checked_cnt;

  int n_writes;
  int n_queries;
  int n_empty;
  int burst_left;
  int fill_ptr;
  int idle_cycles;
  int rdy_mode = 0;
  int mode_left = 0;
  int cyc = 0;

  range_mode_query uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rmq_checker u_mode_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .mismatch_cnt (mismatch_cnt),
    .outstanding  (outstanding),
    .checked_cnt  (checked_cnt)
  );

  always #1 clk = ~clk;

  // receiver backpressure, switching at random among four modes
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (mode_left == 0) begin
      rdy_mode  <= $urandom_range(0, 3);
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    unique case (rdy_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (cyc % 8 == 0);
      default: out_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 3);
    if (r < 7) return DEPTH - 1;
    return $urandom_range(0, DEPTH - 1);
  endfunction

  task automatic send_item(input rmq_pkg::op_t op, input int pos, input int val,
                           input int lo, input int hi);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, FW'(hi), FW'(lo), FW'(val), FW'(pos)};
    do @(posedge clk); while (!in_tready);
    if (op == rmq_pkg::OP_WRITE) n_writes++;
    else if (lo > hi) n_empty++;
    else n_queries++;
  endtask

  task automatic write_elem(input int pos, input int val);
    send_item(rmq_pkg::OP_WRITE, pos, val, $urandom_range(0, DEPTH - 1),
              $urandom_range(0, DEPTH - 1));
  endtask

  task automatic query_range(input int lo, input int hi);
    send_item(rmq_pkg::OP_QUERY, $urandom_range(0, DEPTH - 1), $urandom_range(0, DEPTH - 1),
              lo, hi);
  endtask

  initial begin
    int r;
    int lo;
    int span;
    int hi;
    int waited;
    burst_left = 0;
    n_writes   = 0;
    n_queries  = 0;
    n_empty    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, ties, empty ranges
    write_elem(0, 0);
    write_elem(1, DEPTH - 1);
    write_elem(2, DEPTH - 1);
    write_elem(3, 0);
    write_elem(4, 5);
    write_elem(DEPTH - 1, DEPTH - 1);
    query_range(0, 0);
    query_range(1, 2);
    query_range(0, 3);
    query_range(0, 4);
    query_range(DEPTH - 1, DEPTH - 1);
    query_range(4, 3);
    query_range(DEPTH - 1, 0);
    query_range(1, 0);
    query_range(2, 4);
    write_elem(2, 0);
    query_range(0, 3);
    query_range(0, 4);
    fill_ptr = 5;

    // random: grow a written prefix, overwrite, query inside it, empty ranges
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45 && fill_ptr < DEPTH) begin
        write_elem(fill_ptr, pick_value());
        fill_ptr++;
      end else if (r < 60) begin
        write_elem($urandom_range(0, fill_ptr - 1), pick_value());
      end else if (r < 90) begin
        lo   = $urandom_range(0, fill_ptr - 1);
        span = fill_ptr - 1 - lo;
        if ($urandom_range(0, 9) == 0) hi = lo + $urandom_range(0, span);
        else hi = lo + $urandom_range(0, (span < 15) ? span : 15);
        query_range(lo, hi);
      end else begin
        hi = $urandom_range(0, DEPTH - 2);
        query_range($urandom_range(hi + 1, DEPTH - 1), hi);
      end
    end

    // longest written range, then a changed first element
    query_range(0, fill_ptr - 1);
    write_elem(0, 0);
    query_range(0, fill_ptr - 1);
    query_range(0, 0);
    in_tvalid <= 1'b0;

    waited = 0;
    @(negedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d writes, %0d range queries and %0d empty ranges",
             n_writes, n_queries, n_empty);
    $display("%0d results checked, %0d mismatches, %0d still outstanding",
             checked_cnt, mismatch_cnt, outstanding);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rmq_pkg.sv
hdl/rmq_wrap.sv
hdl/rmq_core.sv
hdl/range_mode_query.sv
tb/rmq_checker.sv
tb/tb_range_mode_query.sv
